/* rtl/core/davs_pkg.sv */
// davs_pkg: shared types, codes and name tables for the dual attribute value scanner.
// Used by davs_match, davs_emit, davs_outq, the top level and the checker. No dependencies.
`default_nettype none

package davs_pkg;

  localparam int unsigned NAME_LEN = 13;
  localparam logic [7:0]  QUOTE    = 8'h22;

  typedef enum logic {
    OP_SCAN  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_FIRST  = 2'd1,
    KIND_SECOND = 2'd2
  } kind_t;

  typedef enum logic {
    PAT_FIRST  = 1'b0,
    PAT_SECOND = 1'b1
  } pattern_t;

  // Per-word command into a matcher
  typedef struct packed {
    logic scan;
    logic clr;
  } cmd_t;

  // One output word
  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_out;
    logic       first_found;
    logic       second_found;
    logic       last;
  } res_t;

  // data-n-a-sg="  /  data-n-a-ts="
  function automatic logic [7:0] name_char(input pattern_t pat, input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "d";
      4'd1:    c = "a";
      4'd2:    c = "t";
      4'd3:    c = "a";
      4'd4:    c = "-";
      4'd5:    c = "n";
      4'd6:    c = "-";
      4'd7:    c = "a";
      4'd8:    c = "-";
      4'd9:    c = (pat == PAT_FIRST) ? 8'("s") : 8'("t");
      4'd10:   c = (pat == PAT_FIRST) ? 8'("g") : 8'("s");
      4'd11:   c = "=";
      4'd12:   c = QUOTE;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/davs_match.sv */
// davs_match: one attribute-name matcher with its value capture memory.
// Depends on davs_pkg.
`default_nettype none

module davs_match #(
  parameter int unsigned VALUE_BYTES = 32,
  parameter int unsigned LW          = $clog2(VALUE_BYTES)
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  davs_pkg::pattern_t      pat,
  input  davs_pkg::cmd_t          cmd,
  input  wire [7:0]               data_byte,
  output logic                    have,
  output logic                    have_nxt,
  output logic [LW-1:0]           len,
  input  wire                     rd_en,
  input  wire [LW-1:0]            rd_addr,
  output logic [7:0]              rd_data
);

  logic [3:0]    pos_r, pos_nxt;
  logic          inval_r, inval_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          have_r;
  logic          wr_en;
  logic [LW:0]   len_p1;
  logic [3:0]    pos_p1;
  logic [7:0]    store [VALUE_BYTES];
  logic [7:0]    rd_data_r;

  assign len_p1 = {1'b0, len_r} + (LW+1)'(1);
  assign pos_p1 = pos_r + 4'd1;

  always_comb begin
    pos_nxt   = pos_r;
    inval_nxt = inval_r;
    len_nxt   = len_r;
    have_nxt  = have_r;
    wr_en     = 1'b0;
    if (cmd.clr) begin
      pos_nxt   = '0;
      inval_nxt = 1'b0;
      len_nxt   = '0;
      have_nxt  = 1'b0;
    end else if (cmd.scan && !have_r) begin
      if (inval_r) begin
        if (data_byte == davs_pkg::QUOTE) begin
          have_nxt  = 1'b1;
          inval_nxt = 1'b0;
        end else if (len_p1 < (LW+1)'(VALUE_BYTES)) begin
          wr_en   = 1'b1;
          len_nxt = len_p1[LW-1:0];
        end else begin
          // overlong: drop byte, abandon capture
          inval_nxt = 1'b0;
          len_nxt   = '0;
        end
      end else if (pos_r < 4'(davs_pkg::NAME_LEN) &&
                   data_byte == davs_pkg::name_char(pat, pos_r)) begin
        if (pos_p1 >= 4'(davs_pkg::NAME_LEN)) begin
          inval_nxt = 1'b1;
          pos_nxt   = '0;
          len_nxt   = '0;
        end else begin
          pos_nxt = pos_p1;
        end
      end else begin
        pos_nxt = (data_byte == davs_pkg::name_char(pat, 4'd0)) ? 4'd1 : 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      inval_r <= 1'b0;
      len_r   <= '0;
      have_r  <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      inval_r <= inval_nxt;
      len_r   <= len_nxt;
      have_r  <= have_nxt;
    end
  end

  // capture memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[len_r] <= data_byte;
    end
    if (rd_en) begin
      rd_data_r <= store[rd_addr];
    end
  end

  assign have    = have_r;
  assign len     = len_r;
  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/core/davs_emit.sv */
// davs_emit: read sequencer that plays out both captured values after completion.
// Depends on davs_pkg; drives the read ports of both davs_match memories.
`default_nettype none

module davs_emit #(
  parameter int unsigned VALUE_BYTES = 32,
  parameter int unsigned LW          = $clog2(VALUE_BYTES)
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            start,
  input  wire [LW-1:0]   len1,
  input  wire [LW-1:0]   len2,
  input  wire            q_full,
  input  wire [7:0]      rd1_data,
  input  wire [7:0]      rd2_data,
  output logic           rd1_en,
  output logic           rd2_en,
  output logic [LW-1:0]  rd_addr,
  output logic           busy,
  output logic           push,
  output davs_pkg::res_t push_res
);

  logic          act_r, act_nxt;
  logic          phase_r, phase_nxt;     // 0: first value, 1: second value
  logic [LW-1:0] idx_r, idx_nxt;
  logic [LW-1:0] len1_r, len2_r;
  logic          pend_r, pend_nxt;
  logic          pend_sec_r;
  logic          pend_last_r;
  logic          issue;
  logic          at_end;
  logic          run_last;

  assign push  = pend_r && !q_full;
  assign issue = act_r && (!pend_r || push);
  assign busy  = act_r || pend_r;

  assign at_end   = phase_r ? (idx_r == len2_r - LW'(1)) : (idx_r == len1_r - LW'(1));
  assign run_last = at_end && (phase_r || len2_r == '0);

  assign rd_addr = idx_r;
  assign rd1_en  = issue && !phase_r;
  assign rd2_en  = issue && phase_r;

  always_comb begin
    act_nxt   = act_r;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    pend_nxt  = issue ? 1'b1 : (push ? 1'b0 : pend_r);
    if (start) begin
      idx_nxt   = '0;
      act_nxt   = (len1 != '0) || (len2 != '0);
      phase_nxt = (len1 == '0);
    end else if (issue) begin
      if (at_end) begin
        idx_nxt = '0;
        if (!phase_r && len2_r != '0) begin
          phase_nxt = 1'b1;
        end else begin
          act_nxt = 1'b0;
        end
      end else begin
        idx_nxt = idx_r + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      act_r  <= act_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    idx_r   <= idx_nxt;
    if (start) begin
      len1_r <= len1;
      len2_r <= len2;
    end
    if (issue) begin
      pend_sec_r  <= phase_r;
      pend_last_r <= run_last;
    end
  end

  always_comb begin
    push_res.kind         = pend_sec_r ? davs_pkg::KIND_SECOND : davs_pkg::KIND_FIRST;
    push_res.char_out     = pend_sec_r ? rd2_data : rd1_data;
    push_res.first_found  = 1'b1;
    push_res.second_found = 1'b1;
    push_res.last         = pend_last_r;
  end

endmodule

`default_nettype wire

/* rtl/core/davs_outq.sv */
// davs_outq: two-word output queue that decouples the result channel from the scan side.
// Depends on davs_pkg.
`default_nettype none

module davs_outq (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  davs_pkg::res_t push_res,
  output logic           full,
  output logic           out_valid,
  input  wire            out_stall,
  output davs_pkg::res_t out_res
);

  davs_pkg::res_t ent [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           pop;

  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign pop       = out_valid && !out_stall;
  assign out_res   = ent[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp_r] <= push_res;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dual_attribute_value_scanner.sv */
// dual_attribute_value_scanner: top level; two name matchers, value emitter, output queue.
// Depends on davs_pkg, davs_match, davs_emit and davs_outq.
//
//   channel | ports                                  | handshake
//   --------+----------------------------------------+------------------
//   in      | in_op, in_data_byte                    | in_valid/in_stall
//   out     | out_kind, out_char_out, out_first_found,| out_valid/out_stall
//           | out_second_found, out_last             |
//
// Cycles: one input word per clock while in_stall is low; its status word enters the
//   output queue the next cycle. The completing word adds one value word per cycle
//   while the queue has room (up to 2*(VALUE_BYTES-1)), paced by the single read port
//   of each capture memory; the input stays stalled until the last one is queued.
// Reset: synchronous, active low; clears matchers, emitter and queue. The capture
//   memories are not cleared, only entries below the captured length are ever read.
// Stalls: a two-word output queue lets a new word in while a result waits; in_stall
//   rises only when the queue is full or a value run is playing out.
`default_nettype none

module dual_attribute_value_scanner #(
  parameter int unsigned VALUE_BYTES = 32
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        in_op,
  input  wire [7:0]  in_data_byte,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_char_out,
  output logic       out_first_found,
  output logic       out_second_found,
  output logic       out_last
);

  localparam int unsigned LW = $clog2(VALUE_BYTES);

  logic           accept;
  davs_pkg::cmd_t cmd;
  logic           have1, have1_nxt, have2, have2_nxt;
  logic [LW-1:0]  len1, len2;
  logic           complete;
  logic           rd1_en, rd2_en;
  logic [LW-1:0]  rd_addr;
  logic [7:0]     rd1_data, rd2_data;
  logic           emit_busy, emit_push;
  davs_pkg::res_t emit_res, stat_res, push_res, out_res;
  logic           q_full, q_push;

  // No new word while the queue is full or a value run owns the output;
  // this also keeps the capture memories free of writes while they are read.
  assign in_stall = q_full || emit_busy;
  assign accept   = in_valid && !in_stall;

  assign cmd.scan = accept && (davs_pkg::op_t'(in_op) == davs_pkg::OP_SCAN);
  assign cmd.clr  = accept && (davs_pkg::op_t'(in_op) == davs_pkg::OP_CLEAR);

  davs_match #(.VALUE_BYTES(VALUE_BYTES), .LW(LW)) u_match1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .pat       (davs_pkg::PAT_FIRST),
    .cmd       (cmd),
    .data_byte (in_data_byte),
    .have      (have1),
    .have_nxt  (have1_nxt),
    .len       (len1),
    .rd_en     (rd1_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd1_data)
  );

  davs_match #(.VALUE_BYTES(VALUE_BYTES), .LW(LW)) u_match2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .pat       (davs_pkg::PAT_SECOND),
    .cmd       (cmd),
    .data_byte (in_data_byte),
    .have      (have2),
    .have_nxt  (have2_nxt),
    .len       (len2),
    .rd_en     (rd2_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd2_data)
  );

  // Both values found on this word for the first time. The completing byte is a
  // quote, so neither length moves on this word and len1/len2 are final.
  assign complete = cmd.scan && !(have1 && have2) && have1_nxt && have2_nxt;

  always_comb begin
    stat_res.kind         = davs_pkg::KIND_STATUS;
    stat_res.char_out     = 8'h00;
    stat_res.first_found  = have1_nxt;
    stat_res.second_found = have2_nxt;
    stat_res.last         = !(complete && (len1 != '0 || len2 != '0));
  end

  davs_emit #(.VALUE_BYTES(VALUE_BYTES), .LW(LW)) u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (complete),
    .len1     (len1),
    .len2     (len2),
    .q_full   (q_full),
    .rd1_data (rd1_data),
    .rd2_data (rd2_data),
    .rd1_en   (rd1_en),
    .rd2_en   (rd2_en),
    .rd_addr  (rd_addr),
    .busy     (emit_busy),
    .push     (emit_push),
    .push_res (emit_res)
  );

  // Status words and value words never compete: the emitter only pushes while busy.
  assign q_push   = accept || emit_push;
  assign push_res = accept ? stat_res : emit_res;

  davs_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_res  (push_res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_char_out     = out_res.char_out;
  assign out_first_found  = out_res.first_found;
  assign out_second_found = out_res.second_found;
  assign out_last         = out_res.last;

endmodule

`default_nettype wire

/* rtl/core/davs_chk.sv */
// davs_chk: port-level checker for dual_attribute_value_scanner, attached by bind.
// Depends on davs_pkg.
`default_nettype none

module davs_chk (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_stall,
  input wire [1:0] out_kind,
  input wire [7:0] out_char_out,
  input wire       out_first_found,
  input wire       out_second_found,
  input wire       out_last
);

  // held result word keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_char_out)
      && $stable(out_last))
    else $error("stalled output word changed");

  // value words only appear once both values are complete
  a_value_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != davs_pkg::KIND_STATUS |-> out_first_found && out_second_found)
    else $error("value word without both found flags");

  // status words carry no character
  a_status_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == davs_pkg::KIND_STATUS |-> out_char_out == 8'h00)
    else $error("status word with non-zero character");

  // a value word that is not the last must be followed by another value word,
  // so the next word to leave after it is never a status word
  a_run_whole: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_kind != davs_pkg::KIND_STATUS && !out_last
      |=> !out_valid || out_kind != davs_pkg::KIND_STATUS)
    else $error("value run broken by a status word");

endmodule

bind dual_attribute_value_scanner davs_chk u_davs_chk (.*);

`default_nettype wire

/* test/tb_dual_attribute_value_scanner.sv */
// tb_dual_attribute_value_scanner: self-checking bench for the dual attribute value scanner.
// Depends on davs_pkg and dual_attribute_value_scanner; a directed table, then random pages
// of attribute names and values, checked word by word against an in-bench scan predictor.
`timescale 1ns / 1ps

module tb_dual_attribute_value_scanner;

  localparam int unsigned   VALUE_BYTES  = 32;
  localparam int unsigned   RANDOM_WORDS = 330;
  localparam davs_pkg::res_t STATUS_IDLE = '{kind: davs_pkg::KIND_STATUS, char_out: 8'h00,
                                             first_found: 1'b0, second_found: 1'b0,
                                             last: 1'b1};
  localparam davs_pkg::res_t NO_WORD     = '0;

  // one row of the directed table; want only counts when typed is set
  typedef struct {
    davs_pkg::op_t  op;
    logic [7:0]     data;
    logic           typed;
    davs_pkg::res_t want;
  } row_t;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_op        = davs_pkg::OP_SCAN;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_stall    = 1'b0;
  wire        in_stall;
  wire        out_valid;
  wire  [1:0] out_kind;
  wire  [7:0] out_char_out;
  wire        out_first_found;
  wire        out_second_found;
  wire        out_last;

  // scan predictor state, one slot per attribute name
  logic [3:0] name_pos   [2];
  logic       capturing  [2];
  logic [4:0] value_len  [2];
  logic       value_done [2];
  logic [7:0] value_buf  [2][VALUE_BYTES];

  davs_pkg::res_t step_words[$];   // words caused by the word just accepted
  davs_pkg::res_t awaited[$];      // words still owed by the block, oldest first
  int unsigned    words_sent     = 0;
  int unsigned    mismatch_count = 0;
  logic           gaps_on        = 1'b1;

  dual_attribute_value_scanner #(.VALUE_BYTES(VALUE_BYTES)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_char_out     (out_char_out),
    .out_first_found  (out_first_found),
    .out_second_found (out_second_found),
    .out_last         (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // the two attribute names differ only at positions 9 and 10
  function automatic logic [7:0] attr_char(davs_pkg::pattern_t p, int unsigned pos);
    string nm;
    nm = (p == davs_pkg::PAT_FIRST) ? "data-n-a-sg=\"" : "data-n-a-ts=\"";
    return nm[pos];
  endfunction

  function automatic void clear_scan();
    for (int p = 0; p < 2; p++) begin
      name_pos[p]   = '0;
      capturing[p]  = 1'b0;
      value_len[p]  = '0;
      value_done[p] = 1'b0;
    end
  endfunction

  function automatic void feed_matcher(davs_pkg::pattern_t p, logic [7:0] c);
    if (value_done[p]) return;
    if (capturing[p]) begin
      // a quote closes the value; the byte that would fill the buffer abandons it
      if (c == davs_pkg::QUOTE) begin
        value_done[p] = 1'b1;
        capturing[p]  = 1'b0;
      end else if (int'(value_len[p]) + 1 < VALUE_BYTES) begin
        value_buf[p][value_len[p]] = c;
        value_len[p]               = value_len[p] + 5'd1;
      end else begin
        capturing[p] = 1'b0;
        value_len[p] = '0;
      end
    end else if (c == attr_char(p, name_pos[p])) begin
      if (name_pos[p] == 4'(davs_pkg::NAME_LEN - 1)) begin
        capturing[p] = 1'b1;
        name_pos[p]  = '0;
        value_len[p] = '0;
      end else begin
        name_pos[p] = name_pos[p] + 4'd1;
      end
    end else begin
      // no deeper backtrack: only a fresh 'd' keeps one character
      name_pos[p] = (c == attr_char(p, 0)) ? 4'd1 : 4'd0;
    end
  endfunction

  function automatic davs_pkg::res_t found_word(davs_pkg::kind_t k, logic [7:0] ch);
    return '{kind: k, char_out: ch, first_found: value_done[davs_pkg::PAT_FIRST],
             second_found: value_done[davs_pkg::PAT_SECOND], last: 1'b0};
  endfunction

  function automatic void predict_word(davs_pkg::op_t op, logic [7:0] c);
    logic was_done;
    step_words.delete();
    if (op == davs_pkg::OP_CLEAR) begin
      clear_scan();
      step_words.push_back(found_word(davs_pkg::KIND_STATUS, 8'h00));
    end else begin
      was_done = value_done[davs_pkg::PAT_FIRST] && value_done[davs_pkg::PAT_SECOND];
      feed_matcher(davs_pkg::PAT_FIRST, c);
      feed_matcher(davs_pkg::PAT_SECOND, c);
      step_words.push_back(found_word(davs_pkg::KIND_STATUS, 8'h00));
      // both values go out once, on the byte that completes the pair
      if (!was_done && value_done[davs_pkg::PAT_FIRST] &&
          value_done[davs_pkg::PAT_SECOND]) begin
        for (int i = 0; i < int'(value_len[davs_pkg::PAT_FIRST]); i++)
          step_words.push_back(found_word(davs_pkg::KIND_FIRST,
                                          value_buf[davs_pkg::PAT_FIRST][i]));
        for (int i = 0; i < int'(value_len[davs_pkg::PAT_SECOND]); i++)
          step_words.push_back(found_word(davs_pkg::KIND_SECOND,
                                          value_buf[davs_pkg::PAT_SECOND][i]));
      end
    end
    step_words[step_words.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // valid is only lowered in a gap, so back-to-back words keep it high
  task automatic send_word(davs_pkg::op_t op, logic [7:0] data, logic typed,
                           davs_pkg::res_t want);
    if (gaps_on) begin
      while ($urandom_range(99) < 31) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_data_byte <= data;
    do @(posedge clk); while (in_stall);
    words_sent++;
    predict_word(op, data);
    if (typed) awaited.push_back(want);
    else foreach (step_words[k]) awaited.push_back(step_words[k]);
  endtask

  task automatic send_name(davs_pkg::pattern_t p, int unsigned upto);
    for (int unsigned k = 0; k < upto; k++)
      send_word(davs_pkg::OP_SCAN, attr_char(p, k), 1'b0, NO_WORD);
  endtask

  // value body then closing quote; long bodies run past the buffer and get dropped
  task automatic send_value();
    int unsigned pick;
    int unsigned nbytes;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 65)      nbytes = $urandom_range(5);
    else if (pick < 80) nbytes = $urandom_range(VALUE_BYTES - 2, 6);
    else if (pick < 90) nbytes = VALUE_BYTES - 1;
    else                nbytes = $urandom_range(VALUE_BYTES + 8, VALUE_BYTES);
    repeat (nbytes) begin
      b = 8'($urandom_range(255));
      if ($urandom_range(99) >= 5) begin
        while (b == davs_pkg::QUOTE) b = 8'($urandom_range(255));
      end
      send_word(davs_pkg::OP_SCAN, b, 1'b0, NO_WORD);
    end
    send_word(davs_pkg::OP_SCAN, davs_pkg::QUOTE, 1'b0, NO_WORD);
  endtask

  task automatic send_noise();
    string      alphabet;
    logic [7:0] b;
    alphabet = "data-nsgt=\"";
    repeat ($urandom_range(6, 1)) begin
      if ($urandom_range(1)) b = alphabet[$urandom_range(alphabet.len() - 1)];
      else                   b = 8'($urandom_range(255));
      send_word(davs_pkg::OP_SCAN, b, 1'b0, NO_WORD);
    end
  endtask

  initial begin
    row_t               directed[$];
    int unsigned        pick;
    davs_pkg::pattern_t p;

    clear_scan();
    // clear, both byte extremes, a 'd' restart inside the name, an empty first
    // value, a byte after it, then clear again
    directed = '{
      '{davs_pkg::OP_CLEAR, 8'hFF,           1'b1, STATUS_IDLE},
      '{davs_pkg::OP_SCAN,  8'h00,           1'b1, STATUS_IDLE},
      '{davs_pkg::OP_SCAN,  8'hFF,           1'b1, STATUS_IDLE},
      '{davs_pkg::OP_SCAN,  "d",             1'b0, NO_WORD},
      '{davs_pkg::OP_SCAN,  "a",             1'b0, NO_WORD},
      '{davs_pkg::OP_SCAN,  "d",             1'b0, NO_WORD},
      '{davs_pkg::OP_SCAN,  "a",             1'b0, NO_WORD},
      '{davs_pkg::OP_SCAN,  "t",             1'b0, NO_WORD},
      '{davs_pkg::OP_SCAN,  "a",             1'b0, NO_WORD},
      '{davs_pkg::OP_SCAN,  "-",             1'b0, NO_WORD},
      '{davs_pkg::OP_SCAN,  "n",             1'b0, NO_WORD},
      '{davs_pkg::OP_SCAN,  "-",             1'b0, NO_WORD},
      '{davs_pkg::OP_SCAN,  "a",             1'b0, NO_WORD},
      '{davs_pkg::OP_SCAN,  "-",             1'b0, NO_WORD},
      '{davs_pkg::OP_SCAN,  "s",             1'b0, NO_WORD},
      '{davs_pkg::OP_SCAN,  "g",             1'b0, NO_WORD},
      '{davs_pkg::OP_SCAN,  "=",             1'b0, NO_WORD},
      '{davs_pkg::OP_SCAN,  davs_pkg::QUOTE, 1'b0, NO_WORD},
      '{davs_pkg::OP_SCAN,  davs_pkg::QUOTE, 1'b0, NO_WORD},
      '{davs_pkg::OP_SCAN,  "x",             1'b0, NO_WORD},
      '{davs_pkg::OP_CLEAR, 8'h00,           1'b1, STATUS_IDLE}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[r]) send_word(directed[r].op, directed[r].data, directed[r].typed,
                                    directed[r].want);

    // random pages: mostly names followed by values, some noise and broken names
    while (words_sent < directed.size() + RANDOM_WORDS) begin
      gaps_on = !(words_sent >= 150 && words_sent < 240);
      if (value_done[davs_pkg::PAT_FIRST] && value_done[davs_pkg::PAT_SECOND]) begin
        // a few ignored bytes after completion, then start a fresh page
        repeat ($urandom_range(3))
          send_word(davs_pkg::OP_SCAN, 8'($urandom_range(255)), 1'b0, NO_WORD);
        send_word(davs_pkg::OP_CLEAR, 8'($urandom_range(255)), 1'b0, NO_WORD);
      end else begin
        pick = $urandom_range(99);
        p    = davs_pkg::pattern_t'($urandom_range(1));
        if (pick < 25) begin
          send_noise();
        end else if (pick < 75) begin
          send_name(pick < 50 ? davs_pkg::PAT_FIRST : davs_pkg::PAT_SECOND,
                    davs_pkg::NAME_LEN);
          send_value();
        end else if (pick < 93) begin
          send_name(p, $urandom_range(davs_pkg::NAME_LEN - 1, 1));
          send_word(davs_pkg::OP_SCAN, 8'($urandom_range(255)), 1'b0, NO_WORD);
        end else begin
          send_word(davs_pkg::OP_CLEAR, 8'($urandom_range(255)), 1'b0, NO_WORD);
        end
      end
    end
    in_valid <= 1'b0;

    while (awaited.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void check_word();
    davs_pkg::res_t want;
    if (awaited.size() == 0) begin
      $error("unexpected word: kind %0d char %0h", out_kind, out_char_out);
      mismatch_count++;
      return;
    end
    want = awaited.pop_front();
    check_field("kind", want.kind, out_kind);
    check_field("char_out", want.char_out, out_char_out);
    check_field("first_found", want.first_found, out_first_found);
    check_field("second_found", want.second_found, out_second_found);
    check_field("last", want.last, out_last);
  endfunction

  // pre-edge values are sampled here; stall for the next edge is drawn once per cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_word();
    out_stall <= gaps_on && ($urandom_range(99) < 31);
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
